### hdl/vmts_pkg.sv
// Shared types and constants for the mode table scanner.
// Depends on nothing; every other file in hdl imports it.
package vmts_pkg;

	localparam int MAX_MODES   = 64;
	localparam int BUF_W       = 54;   // widest bit buffer: 46 held bits plus one byte
	localparam int CNT_W       = 6;
	localparam int ENTRY_BITS  = 41;
	localparam int NEED_BITS   = 47;
	localparam int COUNT_W     = 7;
	localparam int IDXW_W      = 3;
	localparam int EXP_W       = 4;
	localparam int SIZE_W      = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_EXP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_EXP  = 2'd1;

	localparam logic RESULT_SETUP = 1'b0;
	localparam logic RESULT_AUDIO = 1'b1;

	localparam logic ACTION_SETUP = 1'b0;
	localparam logic ACTION_AUDIO = 1'b1;

	typedef enum logic [1:0] {
		PH_SEEK = 2'd0,
		PH_SCAN = 2'd1,
		PH_STOP = 2'd2
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic               result_kind;
		logic               setup_ok;
		logic [COUNT_W-1:0] mode_count;
		logic [IDXW_W-1:0]  mode_index_bits;
		logic [SIZE_W-1:0]  block_size;
		logic               long_block;
	} result_t;

	// Stored outcome of the last setup scan, as seen by the audio path.
	typedef struct packed {
		logic [COUNT_W-1:0]   mode_count;
		logic [IDXW_W-1:0]    index_width;
		logic [MAX_MODES-1:0] flags;
	} mode_info_t;

endpackage

### hdl/vmts_scan.sv
// Setup header scanner: framing bit search, bit buffer and mode entry tests.
// Holds all scan state. Depends on vmts_pkg.
module vmts_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	output vmts_pkg::mode_info_t        info,
	output vmts_pkg::result_t           setup_res
);
	import vmts_pkg::*;

	logic [BUF_W-1:0]     buf_q, buf_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	phase_t               phase_q, phase_d;
	logic [COUNT_W-1:0]   ent_q, ent_d;
	logic [MAX_MODES-1:0] flags_q, flags_d;
	logic [COUNT_W-1:0]   found_q, found_d;
	logic [IDXW_W-1:0]    iw_q, iw_d;

	logic [2:0]           top;
	logic [7:0]           low_mask;
	logic [BUF_W-1:0]     sh;
	logic [CNT_W-1:0]     cnt8;
	logic [3:0]           sa;
	logic [BUF_W-1:0]     entry_sh;
	logic [BUF_W-1:0]     field_sh;
	logic [ENTRY_BITS-1:0] entry;
	logic [5:0]           field;
	logic [COUNT_W-1:0]   ent_inc;
	logic [COUNT_W-1:0]   found_m1;
	logic [IDXW_W-1:0]    width_new;

	function automatic logic [2:0] msb_pos(input logic [7:0] v);
		logic [2:0] p;
		p = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i])
				p = 3'(i);
		end
		return p;
	endfunction

	function automatic logic [IDXW_W-1:0] bit_len(input logic [COUNT_W-1:0] v);
		logic [IDXW_W-1:0] n;
		n = '0;
		for (int i = 0; i < COUNT_W; i++) begin
			if (v[i])
				n = IDXW_W'(i + 1);
		end
		return n;
	endfunction

	assign top      = msb_pos(data_byte);
	assign low_mask = (8'd1 << top) - 8'd1;
	// Bits above the held count are always zero while scanning.
	assign sh       = {buf_q[BUF_W-9:0], data_byte};
	assign cnt8     = cnt_q + 6'd8;
	assign sa       = 4'(cnt8 - 6'(ENTRY_BITS));
	assign entry_sh = sh >> sa;
	assign entry    = entry_sh[ENTRY_BITS-1:0];
	assign field_sh = sh >> (sa - 4'd6);
	assign field    = field_sh[5:0];
	assign ent_inc  = ent_q + 7'd1;

	always_comb begin
		buf_d   = buf_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		ent_d   = ent_q;
		flags_d = flags_q;
		found_d = found_q;
		iw_d    = iw_q;
		unique case (phase_q)
			PH_SEEK: begin
				ent_d   = '0;
				flags_d = '0;
				found_d = '0;
				iw_d    = '0;
				if (data_byte != 8'd0) begin
					buf_d   = BUF_W'(data_byte & low_mask);
					cnt_d   = CNT_W'(top);
					phase_d = PH_SCAN;
				end
			end
			PH_SCAN: begin
				buf_d = sh;
				cnt_d = cnt8;
				if (cnt8 >= 6'(NEED_BITS)) begin
					// Nonzero window or transform type ends the table.
					if (|entry[32:1]) begin
						phase_d = PH_STOP;
					end else begin
						ent_d   = ent_inc;
						flags_d = {flags_q[MAX_MODES-2:0], entry[0]};
						if ({1'b0, field} == ent_q)
							found_d = ent_inc;
						cnt_d = CNT_W'(sa);
						buf_d = sh & ((BUF_W'(1) << sa) - BUF_W'(1));
						if (ent_inc > 7'(MAX_MODES))
							phase_d = PH_STOP;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign found_m1  = found_d - 7'd1;
	assign width_new = (found_d != '0) ? bit_len(found_m1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			cnt_q   <= '0;
			phase_q <= PH_SEEK;
			ent_q   <= '0;
			flags_q <= '0;
			found_q <= '0;
			iw_q    <= '0;
		end else if (en) begin
			flags_q <= flags_d;
			found_q <= found_d;
			if (last_byte) begin
				buf_q   <= '0;
				cnt_q   <= '0;
				phase_q <= PH_SEEK;
				ent_q   <= '0;
				iw_q    <= width_new;
			end else begin
				buf_q   <= buf_d;
				cnt_q   <= cnt_d;
				phase_q <= phase_d;
				ent_q   <= ent_d;
				iw_q    <= iw_d;
			end
		end
	end

	assign info.mode_count  = found_q;
	assign info.index_width = iw_q;
	assign info.flags       = flags_q;

	always_comb begin
		setup_res                 = '0;
		setup_res.result_kind     = RESULT_SETUP;
		setup_res.setup_ok        = (found_d != '0);
		setup_res.mode_count      = found_d;
		setup_res.mode_index_bits = width_new;
	end

endmodule

### hdl/vmts_audio.sv
// Audio packet block size select from the stored mode flags.
// Depends on vmts_pkg.
module vmts_audio (
	input  logic                          [7:0] data_byte,
	input  vmts_pkg::mode_info_t                info,
	input  logic [vmts_pkg::EXP_W-1:0]          short_exp,
	input  logic [vmts_pkg::EXP_W-1:0]          long_exp,
	output vmts_pkg::result_t                   audio_res
);
	import vmts_pkg::*;

	logic [6:0]       idx_mask;
	logic [6:0]       mode;
	logic             flag;
	logic [EXP_W-1:0] e;

	assign idx_mask = ~(7'h7F << info.index_width);
	assign mode     = data_byte[7:1] & idx_mask;
	assign flag     = mode[6] ? 1'b0 : info.flags[mode[5:0]];
	assign e        = flag ? long_exp : short_exp;

	always_comb begin
		audio_res                 = '0;
		audio_res.result_kind     = RESULT_AUDIO;
		audio_res.setup_ok        = (info.mode_count != '0);
		audio_res.mode_count      = info.mode_count;
		audio_res.mode_index_bits = info.index_width;
		audio_res.block_size      = SIZE_W'(1) << e;
		audio_res.long_block      = flag;
	end

endmodule

### hdl/vorbis_mode_table_scanner.sv
// Top level of the mode table scanner: input register, config registers,
// result register. Depends on vmts_pkg, vmts_scan and vmts_audio.
//
//   channel  | handshake                | word
//   item     | item_valid / item_stall  | item (action, data_byte, last_byte)
//   result   | result_valid / result_stall | result (six result fields)
//   cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word per cycle while item_stall is low. A word is registered on acceptance
// and its result enters the result register at the edge on which it advances.
// Reset clears the scan state, the stored mode table and both exponents.
// A stalled result holds the next result-producing word in the input register.
module vorbis_mode_table_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  vmts_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output vmts_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vmts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vmts_pkg::EXP_W-1:0]          cfg_data
);
	import vmts_pkg::*;

	item_t            item_s1;
	logic             valid_s1;
	logic             needs_out;
	logic             advance;
	logic [EXP_W-1:0] short_q, long_q;
	mode_info_t       info;
	result_t          setup_res, audio_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= '0;
			long_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHORT_EXP: short_q <= cfg_data;
				CFG_LONG_EXP:  long_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign needs_out  = (item_s1.action == ACTION_AUDIO) || item_s1.last_byte;
	assign advance    = valid_s1 && (!needs_out || !result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!item_stall)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	vmts_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance && (item_s1.action == ACTION_SETUP)),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.info      (info),
		.setup_res (setup_res)
	);

	vmts_audio u_audio (
		.data_byte (item_s1.data_byte),
		.info      (info),
		.short_exp (short_q),
		.long_exp  (long_q),
		.audio_res (audio_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (advance && needs_out)
			result_valid <= 1'b1;
		else if (!result_stall)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && needs_out)
			result <= (item_s1.action == ACTION_AUDIO) ? audio_res : setup_res;
	end

endmodule
